// ===== hw/rtl/multi_channel_rate_divider_macros.svh =====
// Assertion macros used by the rate divider sequencer.
`ifndef MULTI_CHANNEL_RATE_DIVIDER_MACROS_SVH
`define MULTI_CHANNEL_RATE_DIVIDER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold on every clock edge out of reset.
`define MCRD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mcrd assertion failed");

// Condition that must be followed by a consequence in the next cycle.
`define MCRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcrd assertion failed");

`else

`define MCRD_ASSERT(lbl, prop)
`define MCRD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/mcrd_pkg.sv =====
// Types and constants of the multi-channel rate divider.
package mcrd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int STEP_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [7:0] BASE_RATE_RST = 8'd50;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [2:0] ST_FIRED    = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_ADDED    = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ADD,
        OP_REMOVE,
        OP_TICK,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        logic        valid;
        logic        fire;
        logic [15:0] handle;
        logic [7:0]  rate;
        logic [7:0]  count;
    } entry_t;

    typedef struct packed {
        cell_op_t    op;
        logic [15:0] handle;
        logic [7:0]  rate;
        logic [7:0]  base;
    } cell_cmd_t;

    typedef struct packed {
        logic        full;
        logic        found;
        logic        any_fire;
        logic        any_pend;
        logic        head_fire;
        logic        later_fire;
        logic [15:0] head_handle;
    } chain_stat_t;

endpackage

// ===== hw/rtl/mcrd_ifs.sv =====
// Handshake channels of the rate divider: request, response and configuration.
interface mcrd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] handle;
    logic [7:0]  rate;

    modport source (output valid, kind, handle, rate, input ready);
    modport sink (input valid, kind, handle, rate, output ready);
endinterface

interface mcrd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] fired_handle;
    logic [31:0] tick_count;
    logic        last;

    modport source (output valid, status, fired_handle, tick_count, last, input ready);
    modport sink (input valid, status, fired_handle, tick_count, last, output ready);
endinterface

interface mcrd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_rate;

    modport source (output valid, base_rate, input ready);
    modport sink (input valid, base_rate, output ready);
endinterface

// ===== hw/rtl/mcrd_cell.sv =====
// One list slot: holds an entry and moves it to or from its neighbors.
module mcrd_cell
    import mcrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    left,
    input  entry_t    right,
    input  logic      found_in,
    output logic      found_out,
    output entry_t    cur,
    output logic      fire_now
);

    logic        valid_reg, valid_next;
    logic        fire_reg, fire_next;
    logic [15:0] handle_reg, handle_next;
    logic [7:0]  rate_reg, rate_next;
    logic [7:0]  count_reg, count_next;
    logic [8:0]  diff;
    logic [7:0]  refill;
    logic        at_or_below;
    logic        match;

    assign cur = '{valid: valid_reg, fire: fire_reg, handle: handle_reg,
                   rate: rate_reg, count: count_reg};

    assign diff        = {1'b0, count_reg} - {1'b0, rate_reg};
    assign at_or_below = diff[8] || (diff == 9'd0);
    assign refill      = diff[7:0] + cmd.base;
    assign fire_now    = valid_reg && at_or_below;

    assign match     = valid_reg && (handle_reg == cmd.handle);
    assign found_out = found_in || match;

    always_comb
    begin
        valid_next  = valid_reg;
        fire_next   = fire_reg;
        handle_next = handle_reg;
        rate_next   = rate_reg;
        count_next  = count_reg;
        case (cmd.op)
            OP_ADD:
            begin
                valid_next  = left.valid;
                fire_next   = left.fire;
                handle_next = left.handle;
                rate_next   = left.rate;
                count_next  = left.count;
            end
            OP_REMOVE:
            begin
                // close the gap from the first match on
                if (found_out)
                begin
                    valid_next  = right.valid;
                    fire_next   = right.fire;
                    handle_next = right.handle;
                    rate_next   = right.rate;
                    count_next  = right.count;
                end
            end
            OP_TICK:
            begin
                fire_next  = fire_now;
                count_next = at_or_below ? refill : diff[7:0];
            end
            OP_ROTATE:
            begin
                valid_next  = right.valid;
                fire_next   = right.fire;
                handle_next = right.handle;
                rate_next   = right.rate;
                count_next  = right.count;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fire_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fire_reg  <= fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        rate_reg   <= rate_next;
        count_reg  <= count_next;
    end

endmodule

// ===== hw/rtl/mcrd_ctrl.sv =====
// Sequencer: takes requests, drives the cell chain, holds the response word.
`include "multi_channel_rate_divider_macros.svh"

module mcrd_ctrl
    import mcrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mcrd_req_if.sink    req,
    mcrd_rsp_if.source  rsp,
    mcrd_cfg_if.sink    cfg,
    input  chain_stat_t stat,
    output cell_cmd_t   cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [7:0]        base_reg;
    logic [31:0]       ticks_reg, ticks_next;
    logic              ov_reg, ov_next;
    logic [2:0]        status_reg, status_next;
    logic [15:0]       handle_reg, handle_next;
    logic [31:0]       count_reg, count_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic              take;
    logic              advance;
    logic              load;

    assign cfg.ready = 1'b1;

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign take      = req.valid && req.ready;
    assign advance   = (state_reg == S_SCAN) && (!stat.head_fire || out_free);

    assign rsp.valid        = ov_reg;
    assign rsp.status       = status_reg;
    assign rsp.fired_handle = handle_reg;
    assign rsp.tick_count   = count_reg;
    assign rsp.last         = last_reg;

    always_comb
    begin
        cmd.handle = req.handle;
        cmd.base   = base_reg;
        cmd.rate   = ((req.rate == 8'd0) || (req.rate > base_reg)) ? base_reg : req.rate;
        cmd.op     = OP_HOLD;

        state_next  = state_reg;
        step_next   = step_reg;
        ticks_next  = ticks_reg;
        load        = 1'b0;
        status_next = status_reg;
        handle_next = handle_reg;
        count_next  = count_reg;
        last_next   = last_reg;

        if (take)
        begin
            load        = 1'b1;
            handle_next = req.handle;
            count_next  = ticks_reg;
            last_next   = 1'b1;
            case (req.kind)
                KIND_TICK:
                begin
                    cmd.op      = OP_TICK;
                    ticks_next  = ticks_reg + 32'd1;
                    count_next  = ticks_next;
                    status_next = ST_NONE;
                    // firing entries are reported during the rotation
                    if (stat.any_fire)
                    begin
                        load       = 1'b0;
                        state_next = S_SCAN;
                        step_next  = '0;
                    end
                end
                KIND_ADD:
                begin
                    cmd.op      = stat.full ? OP_HOLD : OP_ADD;
                    status_next = stat.full ? ST_FULL : ST_ADDED;
                end
                KIND_REMOVE:
                begin
                    cmd.op      = OP_REMOVE;
                    status_next = stat.found ? ST_REMOVED : ST_NOTFOUND;
                end
                default:
                begin
                    ticks_next  = '0;
                    count_next  = '0;
                    status_next = ST_NONE;
                end
            endcase
        end
        else if (advance)
        begin
            cmd.op    = OP_ROTATE;
            step_next = step_reg + STEP_W'(1);
            if (stat.head_fire)
            begin
                load        = 1'b1;
                status_next = ST_FIRED;
                handle_next = stat.head_handle;
                count_next  = ticks_reg;
                last_next   = !stat.later_fire;
            end
            if (step_reg == STEP_W'(MAX_ENTRIES - 1))
            begin
                state_next = S_IDLE;
            end
        end

        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            base_reg  <= BASE_RATE_RST;
            ticks_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ticks_reg <= ticks_next;
            ov_reg    <= ov_next;
            if (cfg.valid && cfg.ready)
            begin
                base_reg <= cfg.base_rate;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            handle_reg <= handle_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
        end
    end

    `MCRD_ASSERT(a_idle_no_pending, (state_reg == S_IDLE) |-> !stat.any_pend)
    `MCRD_ASSERT_NEXT(a_tick_fire_scans, take && (req.kind == KIND_TICK) && stat.any_fire,
                      state_reg == S_SCAN)
    `MCRD_ASSERT_NEXT(a_scan_end_clean,
                      advance && (step_reg == STEP_W'(MAX_ENTRIES - 1)),
                      (state_reg == S_IDLE) && !stat.any_pend)
    `MCRD_ASSERT(a_ticks_step, (ticks_reg == $past(ticks_reg)) ||
                 (ticks_reg == $past(ticks_reg) + 32'd1) || (ticks_reg == 32'd0))

endmodule

// ===== hw/rtl/multi_channel_rate_divider.sv =====
// Multi-channel rate divider: ordered list of rate-divided entries driven by ticks.
//
// Channels: req takes one word (kind, handle, rate); rsp gives result words
// (status, fired_handle, tick_count, last); cfg writes base_rate and is always ready.
// The list lives in a chain of MAX_ENTRIES cells, newest entry in cell 0.
// Add, remove and clear-tick-count words give one result word in the cycle after
// acceptance. On acceptance an add with room shifts the whole chain by one cell and
// a remove shifts the cells from the match on. A tick updates all counters in the
// cycle it is accepted. If nothing fires, one "nothing fired" word follows in the
// next cycle. Otherwise the chain rotates once around, and each firing entry is
// reported as it passes cell 0, in list order, last set on the final one.
// req takes the next word only while idle and the response word is free or being
// taken; after a firing tick it waits for the end of the rotation.
// A stalled rsp holds the current word; the rotation goes on until the next firing
// entry reaches cell 0 and pauses there until the word is taken.
// Reset empties the list, clears the tick count and sets base_rate to 50.
module multi_channel_rate_divider
    import mcrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mcrd_req_if.sink   req,
    mcrd_rsp_if.source rsp,
    mcrd_cfg_if.sink   cfg
);

    cell_cmd_t   cmd;
    chain_stat_t stat;
    entry_t      cells   [MAX_ENTRIES];
    entry_t      lefts   [MAX_ENTRIES];
    entry_t      rights  [MAX_ENTRIES];
    logic        fires   [MAX_ENTRIES];
    logic        found_c [MAX_ENTRIES+1];
    entry_t      new_entry;
    entry_t      tail_in;

    assign new_entry = '{valid: 1'b1, fire: 1'b0, handle: cmd.handle,
                         rate: cmd.rate, count: cmd.base};

    // wrap cell 0 round to the tail, its fire flag already reported
    always_comb
    begin
        tail_in = '0;
        if (cmd.op == OP_ROTATE)
        begin
            tail_in      = cells[0];
            tail_in.fire = 1'b0;
        end
    end

    assign found_c[0] = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign lefts[i] = new_entry;
        end
        else
        begin : g_body
            assign lefts[i] = cells[i-1];
        end
        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign rights[i] = tail_in;
        end
        else
        begin : g_inner
            assign rights[i] = cells[i+1];
        end

        mcrd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left      (lefts[i]),
            .right     (rights[i]),
            .found_in  (found_c[i]),
            .found_out (found_c[i+1]),
            .cur       (cells[i]),
            .fire_now  (fires[i])
        );
    end

    always_comb
    begin
        stat.full        = cells[MAX_ENTRIES-1].valid;
        stat.found       = found_c[MAX_ENTRIES];
        stat.head_fire   = cells[0].fire;
        stat.head_handle = cells[0].handle;
        stat.any_fire    = 1'b0;
        stat.any_pend    = 1'b0;
        stat.later_fire  = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            stat.any_fire = stat.any_fire | fires[i];
            stat.any_pend = stat.any_pend | cells[i].fire;
            if (i > 0)
            begin
                stat.later_fire = stat.later_fire | cells[i].fire;
            end
        end
    end

    mcrd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .stat  (stat),
        .cmd   (cmd)
    );

endmodule
